// File: hdl/tun_pkg.sv
`timescale 1ns / 1ps

package tun_pkg;

    // Vertex store and coordinate format
    localparam int VERTEX_DEPTH = 1024;
    localparam int IDXW         = $clog2(VERTEX_DEPTH);
    localparam int COORD_WIDTH  = 16;
    localparam int VTXW         = 3 * COORD_WIDTH;

    // Datapath widths
    localparam int DIFW  = COORD_WIDTH + 1;     // edge component
    localparam int PRODW = 2 * DIFW - 1;       // one cross product term
    localparam int CRSW  = PRODW + 1;          // cross product component
    localparam int MAGW  = CRSW - 1;           // its magnitude
    localparam int SQW   = 2 * MAGW;           // squared magnitude
    localparam int SUMW  = SQW + 2;            // squared length
    localparam int FRACW = 14;                 // Q1.14 fraction bits
    localparam int NSTEP = FRACW;              // one root bit per stage
    localparam int QW    = FRACW + 1;          // unit magnitude, up to 1.0
    localparam int PW    = SUMW + FRACW;       // q * S
    localparam int RW    = SUMW + 2 * FRACW + 1; // remainder and trial term
    localparam int OUTW  = 16;
    localparam logic [QW-1:0] UNIT_ONE = QW'(1) << FRACW;

    // Request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_FACE = 1'b1;

    // Pipeline stage numbers
    localparam int ST_READ = 1;
    localparam int ST_DIFF = 2;
    localparam int ST_PROD = 3;
    localparam int ST_CRSS = 4;
    localparam int ST_SQR  = 5;
    localparam int ST_SUM  = 6;
    localparam int ST_INIT = 7;
    localparam int ST_OUT  = ST_INIT + NSTEP + 1;
    localparam int NSTAGE  = ST_OUT;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vtx_t;

    typedef struct packed {
        logic [NSTAGE:1] en;
    } pipe_ctrl_t;

endpackage

// File: hdl/triangle_unit_normal_core.sv
`timescale 1ns / 1ps

// Triangle face unit normal.
// Request channel (req_valid / req_stall): req_type 0 writes one vertex
// (vertex_index, coord_x/y/z, Q7.8) into the store and gives no response;
// req_type 1 names three stored corners a, b, c of a face.
// Response channel (rsp_valid / rsp_stall): one transfer per face, with
// normal_x/y/z in Q1.14 (truncated toward zero, within +/-1.0) of the
// cross product (a - b) x (b - c), and degenerate set with an all-zero
// normal when that cross product is zero.
// Pipeline: 22 register stages. Throughput: one request per cycle while the
// response is not stalled, since every stage is registered and advances
// together; the fourteen-stage bit-per-stage root search on all three lanes
// sets most of the latency.
// A vertex written by a load is visible to a face request in the next cycle.
// Reset clears the stage valid bits only; the vertex store keeps no reset
// value and must be written before it is read.
// A stalled response holds; stages behind it keep filling any empty slots,
// and req_stall rises only when every stage holds a face.

module triangle_unit_normal_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   req_valid,
    output logic                                   req_stall,
    input  logic                                   req_type,
    input  logic [tun_pkg::IDXW-1:0]               vertex_index,
    input  logic signed [tun_pkg::COORD_WIDTH-1:0] coord_x,
    input  logic signed [tun_pkg::COORD_WIDTH-1:0] coord_y,
    input  logic signed [tun_pkg::COORD_WIDTH-1:0] coord_z,
    input  logic [tun_pkg::IDXW-1:0]               face_index_a,
    input  logic [tun_pkg::IDXW-1:0]               face_index_b,
    input  logic [tun_pkg::IDXW-1:0]               face_index_c,
    output logic                                   rsp_valid,
    input  logic                                   rsp_stall,
    output logic signed [tun_pkg::OUTW-1:0]        normal_x,
    output logic signed [tun_pkg::OUTW-1:0]        normal_y,
    output logic signed [tun_pkg::OUTW-1:0]        normal_z,
    output logic                                   degenerate
);

    import tun_pkg::*;

    logic [NSTAGE:1] valid_reg;
    logic [NSTAGE:1] en;
    pipe_ctrl_t      ctrl;
    logic            req_xfer;
    logic            load_we;
    logic [VTXW-1:0] wdata;
    logic [VTXW-1:0] rd_a, rd_b, rd_c;
    vtx_t            va, vb, vc;
    logic [2:0][SQW-1:0] sq;
    logic [2:0]      neg;

    // Advance a stage when it is empty or the stage after it advances
    always_comb
    begin
        en[NSTAGE] = !valid_reg[NSTAGE] || !rsp_stall;
        for (int i = NSTAGE - 1; i >= 1; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign ctrl.en   = en;
    assign req_stall = !en[ST_READ];
    assign req_xfer  = req_valid && !req_stall;
    assign load_we   = req_xfer && (req_type == REQ_LOAD);
    assign wdata     = {coord_x, coord_y, coord_z};

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[ST_READ])
            begin
                valid_reg[ST_READ] <= req_xfer && (req_type == REQ_FACE);
            end
            for (int i = ST_READ + 1; i <= NSTAGE; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Three copies of the vertex store, one read port per corner
    tun_ram #(.DEPTH(VERTEX_DEPTH), .WIDTH(VTXW)) u_ram_a (
        .clk   (clk),
        .we    (load_we),
        .waddr (vertex_index),
        .wdata (wdata),
        .re    (en[ST_READ]),
        .raddr (face_index_a),
        .rdata (rd_a)
    );

    tun_ram #(.DEPTH(VERTEX_DEPTH), .WIDTH(VTXW)) u_ram_b (
        .clk   (clk),
        .we    (load_we),
        .waddr (vertex_index),
        .wdata (wdata),
        .re    (en[ST_READ]),
        .raddr (face_index_b),
        .rdata (rd_b)
    );

    tun_ram #(.DEPTH(VERTEX_DEPTH), .WIDTH(VTXW)) u_ram_c (
        .clk   (clk),
        .we    (load_we),
        .waddr (vertex_index),
        .wdata (wdata),
        .re    (en[ST_READ]),
        .raddr (face_index_c),
        .rdata (rd_c)
    );

    assign va = vtx_t'(rd_a);
    assign vb = vtx_t'(rd_b);
    assign vc = vtx_t'(rd_c);

    tun_cross u_cross (
        .clk  (clk),
        .ctrl (ctrl),
        .va   (va),
        .vb   (vb),
        .vc   (vc),
        .sq   (sq),
        .neg  (neg)
    );

    tun_norm u_norm (
        .clk  (clk),
        .ctrl (ctrl),
        .sq   (sq),
        .neg  (neg),
        .nx   (normal_x),
        .ny   (normal_y),
        .nz   (normal_z),
        .deg  (degenerate)
    );

    assign rsp_valid = valid_reg[NSTAGE];

    // A zero-length face gives an all-zero normal
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
        else $error("degenerate face with nonzero normal");

    // Components stay within +/-1.0
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> normal_x <= $signed(OUTW'(UNIT_ONE))
                   && normal_x >= -$signed(OUTW'(UNIT_ONE))
                   && normal_y <= $signed(OUTW'(UNIT_ONE))
                   && normal_y >= -$signed(OUTW'(UNIT_ONE))
                   && normal_z <= $signed(OUTW'(UNIT_ONE))
                   && normal_z >= -$signed(OUTW'(UNIT_ONE)))
        else $error("normal component out of range");

    // Requests are held back only when no stage is empty
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> &valid_reg)
        else $error("request stalled with a bubble in the pipeline");

    // A stalled response is neither dropped nor replaced
    a_hold_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(normal_x) && $stable(degenerate))
        else $error("stalled response changed");

endmodule

// File: hdl/tun_ram.sv
`timescale 1ns / 1ps

module tun_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while the stage is stalled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/tun_cross.sv
`timescale 1ns / 1ps

module tun_cross (
    input  logic                                  clk,
    input  tun_pkg::pipe_ctrl_t                   ctrl,
    input  tun_pkg::vtx_t                         va,
    input  tun_pkg::vtx_t                         vb,
    input  tun_pkg::vtx_t                         vc,
    output logic [2:0][tun_pkg::SQW-1:0]          sq,
    output logic [2:0]                            neg
);

    import tun_pkg::*;

    logic signed [DIFW-1:0]  d1x_reg, d1y_reg, d1z_reg, d2x_reg, d2y_reg, d2z_reg;
    logic signed [PRODW-1:0] pyz_reg, pzy_reg, pzx_reg, pxz_reg, pxy_reg, pyx_reg;
    logic signed [CRSW-1:0]  c_next [0:2];
    logic [MAGW-1:0]         mag_next [0:2];
    logic [MAGW-1:0]         mag_reg [0:2];
    logic [2:0]              neg4_reg;
    logic [2:0][SQW-1:0]     sq_reg;
    logic [2:0]              neg5_reg;

    // Edge vectors a - b and b - c
    always_ff @(posedge clk)
    begin
        if (ctrl.en[ST_DIFF])
        begin
            d1x_reg <= DIFW'(va.x) - DIFW'(vb.x);
            d1y_reg <= DIFW'(va.y) - DIFW'(vb.y);
            d1z_reg <= DIFW'(va.z) - DIFW'(vb.z);
            d2x_reg <= DIFW'(vb.x) - DIFW'(vc.x);
            d2y_reg <= DIFW'(vb.y) - DIFW'(vc.y);
            d2z_reg <= DIFW'(vb.z) - DIFW'(vc.z);
        end
    end

    // Six signed products of the cross product
    always_ff @(posedge clk)
    begin
        if (ctrl.en[ST_PROD])
        begin
            pyz_reg <= PRODW'(d1y_reg) * PRODW'(d2z_reg);
            pzy_reg <= PRODW'(d1z_reg) * PRODW'(d2y_reg);
            pzx_reg <= PRODW'(d1z_reg) * PRODW'(d2x_reg);
            pxz_reg <= PRODW'(d1x_reg) * PRODW'(d2z_reg);
            pxy_reg <= PRODW'(d1x_reg) * PRODW'(d2y_reg);
            pyx_reg <= PRODW'(d1y_reg) * PRODW'(d2x_reg);
        end
    end

    // Cross product components as sign and magnitude
    always_comb
    begin
        c_next[0] = CRSW'(pyz_reg) - CRSW'(pzy_reg);
        c_next[1] = CRSW'(pzx_reg) - CRSW'(pxz_reg);
        c_next[2] = CRSW'(pxy_reg) - CRSW'(pyx_reg);
        for (int l = 0; l < 3; l++)
        begin
            mag_next[l] = c_next[l][CRSW-1] ? MAGW'(-c_next[l]) : MAGW'(c_next[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[ST_CRSS])
        begin
            for (int l = 0; l < 3; l++)
            begin
                mag_reg[l]  <= mag_next[l];
                neg4_reg[l] <= c_next[l][CRSW-1];
            end
        end
    end

    // Squared magnitudes
    always_ff @(posedge clk)
    begin
        if (ctrl.en[ST_SQR])
        begin
            for (int l = 0; l < 3; l++)
            begin
                sq_reg[l] <= SQW'(mag_reg[l]) * SQW'(mag_reg[l]);
            end
            neg5_reg <= neg4_reg;
        end
    end

    assign sq  = sq_reg;
    assign neg = neg5_reg;

endmodule

// File: hdl/tun_norm.sv
`timescale 1ns / 1ps

module tun_norm (
    input  logic                                  clk,
    input  tun_pkg::pipe_ctrl_t                   ctrl,
    input  logic [2:0][tun_pkg::SQW-1:0]          sq,
    input  logic [2:0]                            neg,
    output logic signed [tun_pkg::OUTW-1:0]       nx,
    output logic signed [tun_pkg::OUTW-1:0]       ny,
    output logic signed [tun_pkg::OUTW-1:0]       nz,
    output logic                                  deg
);

    import tun_pkg::*;

    // Length stage
    logic [SUMW-1:0]     s6_reg;
    logic [2:0][SQW-1:0] c2_6_reg;
    logic [2:0]          neg6_reg;

    // Root stages; index 0 is the setup stage
    logic [RW-1:0]   r_reg   [0:NSTEP][0:2];
    logic [PW-1:0]   p_reg   [0:NSTEP][0:2];
    logic [QW-1:0]   q_reg   [0:NSTEP][0:2];
    logic [SUMW-1:0] s_reg   [0:NSTEP];
    logic [2:0]      sat_reg [0:NSTEP];
    logic [2:0]      neg_reg [0:NSTEP];
    logic            deg_reg [0:NSTEP];

    logic [RW-1:0]   trial   [1:NSTEP][0:2];
    logic [RW:0]     diff    [1:NSTEP][0:2];
    logic [RW-1:0]   r_next  [1:NSTEP][0:2];
    logic [PW-1:0]   p_next  [1:NSTEP][0:2];
    logic [QW-1:0]   q_next  [1:NSTEP][0:2];

    logic [QW-1:0]          mag_out [0:2];
    logic signed [OUTW-1:0] n_next  [0:2];
    logic signed [OUTW-1:0] n_reg   [0:2];
    logic                   deg_out_reg;

    // Sum the squares into the squared length
    always_ff @(posedge clk)
    begin
        if (ctrl.en[ST_SUM])
        begin
            s6_reg   <= SUMW'(sq[0]) + SUMW'(sq[1]) + SUMW'(sq[2]);
            c2_6_reg <= sq;
            neg6_reg <= neg;
        end
    end

    // One root bit per stage: accept bit 2^k when R >= 2^(k+1)*qS + 4^k*S
    always_comb
    begin
        for (int j = 1; j <= NSTEP; j++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                trial[j][l] = (RW'(p_reg[j-1][l]) << (NSTEP - j + 1))
                            + (RW'(s_reg[j-1]) << (2 * (NSTEP - j)));
                diff[j][l]  = {1'b0, r_reg[j-1][l]} - {1'b0, trial[j][l]};
                if (!diff[j][l][RW])
                begin
                    r_next[j][l] = diff[j][l][RW-1:0];
                    p_next[j][l] = p_reg[j-1][l] + (PW'(s_reg[j-1]) << (NSTEP - j));
                    q_next[j][l] = q_reg[j-1][l] | (QW'(1) << (NSTEP - j));
                end
                else
                begin
                    r_next[j][l] = r_reg[j-1][l];
                    p_next[j][l] = p_reg[j-1][l];
                    q_next[j][l] = q_reg[j-1][l];
                end
            end
        end
    end

    // Set up the search, then advance it one bit per stage
    always_ff @(posedge clk)
    begin
        if (ctrl.en[ST_INIT])
        begin
            for (int l = 0; l < 3; l++)
            begin
                r_reg[0][l]   <= RW'(c2_6_reg[l]) << (2 * FRACW);
                p_reg[0][l]   <= '0;
                q_reg[0][l]   <= '0;
                sat_reg[0][l] <= (s6_reg <= SUMW'(c2_6_reg[l]));
            end
            s_reg[0]   <= s6_reg;
            neg_reg[0] <= neg6_reg;
            deg_reg[0] <= (s6_reg == '0);
        end
        for (int j = 1; j <= NSTEP; j++)
        begin
            if (ctrl.en[ST_INIT + j])
            begin
                for (int l = 0; l < 3; l++)
                begin
                    r_reg[j][l] <= r_next[j][l];
                    p_reg[j][l] <= p_next[j][l];
                    q_reg[j][l] <= q_next[j][l];
                end
                s_reg[j]   <= s_reg[j-1];
                sat_reg[j] <= sat_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                deg_reg[j] <= deg_reg[j-1];
            end
        end
    end

    // Apply saturation, zero length and sign
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (deg_reg[NSTEP])
            begin
                mag_out[l] = '0;
            end
            else if (sat_reg[NSTEP][l])
            begin
                mag_out[l] = UNIT_ONE;
            end
            else
            begin
                mag_out[l] = q_reg[NSTEP][l];
            end
            n_next[l] = neg_reg[NSTEP][l] ? -OUTW'(mag_out[l]) : OUTW'(mag_out[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[ST_OUT])
        begin
            for (int l = 0; l < 3; l++)
            begin
                n_reg[l] <= n_next[l];
            end
            deg_out_reg <= deg_reg[NSTEP];
        end
    end

    assign nx  = n_reg[0];
    assign ny  = n_reg[1];
    assign nz  = n_reg[2];
    assign deg = deg_out_reg;

endmodule
